// ----- src/segment_intersect_2d_defines.svh -----
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECT_2D_DEFINES_SVH
`define SEGMENT_INTERSECT_2D_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SGI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SGI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sgi_pkg.sv -----
// shared widths, stage indexes and types for the segment intersection block
package sgi_pkg;

  localparam int COORD_W  = 16;
  localparam int T_FRAC   = 16;
  localparam int T_INT    = 4;
  localparam int T_W      = T_INT + T_FRAC;
  localparam int THR_W    = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int REM_W    = SUM_W + T_W;
  localparam int HIT_PW   = DIFF_W + T_W;
  localparam int DIV_BPS  = 2;
  localparam int DIV_ST   = (T_W + DIV_BPS - 1) / DIV_BPS;

  localparam int PS_DIFF  = 0;
  localparam int PS_PROD  = 1;
  localparam int PS_SUB   = 2;
  localparam int PS_ABS   = 3;
  localparam int PS_DIV0  = 4;
  localparam int PS_SAT   = PS_DIV0 + DIV_ST;
  localparam int PS_MUL   = PS_SAT + 1;
  localparam int PS_OUT   = PS_MUL + 1;
  localparam int NST      = PS_OUT + 1;

  localparam int IN_W     = 8 * COORD_W;
  localparam int OUT_DW   = 2 * T_W + 2 * COORD_W;
  localparam int OUT_DWP  = ((OUT_DW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_INSIDE  = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef struct packed {
    logic                      par;
    logic                      neg1;
    logic                      neg2;
    logic signed [COORD_W-1:0] asx;
    logic signed [COORD_W-1:0] asy;
    logic signed [DIFF_W-1:0]  dax;
    logic signed [DIFF_W-1:0]  day;
  } side_t;

endpackage

// ----- src/sgi_div.sv -----
// pipelined restoring divider, two quotient bits per stage, with overflow flag
module sgi_div (
  input  logic                        clk,
  input  logic [sgi_pkg::DIV_ST-1:0]  stage_en,
  input  logic [sgi_pkg::SUM_W-1:0]   num_mag,
  input  logic [sgi_pkg::SUM_W-1:0]   den_mag,
  output logic [sgi_pkg::T_W-1:0]     quot,
  output logic                        ovf
);
  import sgi_pkg::*;

  logic [REM_W-1:0] rem_in  [DIV_ST];
  logic [SUM_W-1:0] den_in  [DIV_ST];
  logic [T_W-1:0]   q_in    [DIV_ST];
  logic             ovf_in  [DIV_ST];
  logic [REM_W-1:0] rem_nxt [DIV_ST];
  logic [T_W-1:0]   q_nxt   [DIV_ST];
  logic [REM_W-1:0] rem_r   [DIV_ST];
  logic [SUM_W-1:0] den_r   [DIV_ST];
  logic [T_W-1:0]   q_r     [DIV_ST];
  logic             ovf_r   [DIV_ST];

  // quotient reaches 2^T_W exactly when num >= den * 2^T_INT
  assign rem_in[0] = REM_W'({num_mag, {T_FRAC{1'b0}}});
  assign den_in[0] = den_mag;
  assign q_in[0]   = '0;
  assign ovf_in[0] = ({{T_INT{1'b0}}, num_mag} >= {den_mag, {T_INT{1'b0}}});

  for (genvar s = 0; s < DIV_ST; s++) begin : g_st
    if (s > 0) begin : g_chain
      assign rem_in[s] = rem_r[s-1];
      assign den_in[s] = den_r[s-1];
      assign q_in[s]   = q_r[s-1];
      assign ovf_in[s] = ovf_r[s-1];
    end

    always_comb begin : p_step
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] dsh;
      logic [T_W-1:0]   q;
      int               b;
      r = rem_in[s];
      q = q_in[s];
      for (int j = 0; j < DIV_BPS; j++) begin
        b   = T_W - 1 - s * DIV_BPS - j;
        dsh = REM_W'(den_in[s]) << b;
        if (b >= 0 && r >= dsh) begin
          r = r - dsh;
          q = q | (T_W'(1) << b);
        end
      end
      rem_nxt[s] = r;
      q_nxt[s]   = q;
    end

    always_ff @(posedge clk) begin
      if (stage_en[s]) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_in[s];
        q_r[s]   <= q_nxt[s];
        ovf_r[s] <= ovf_in[s];
      end
    end
  end

  assign quot = q_r[DIV_ST-1];
  assign ovf  = ovf_r[DIV_ST-1];

endmodule

// ----- src/segment_intersect_2d.sv -----
// top level: pipelined 2-d segment intersection with parameters and crossing point
//
//  channel  dir  payload
//  in_      in   tdata: a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y
//  out_     out  tdata: t_first, t_second, hit_x, hit_y; tuser: status
//  cfg_     in   wdata: parallel_threshold
//
// one word per cycle while the output is not stalled; a result is presented through
// 17 register stages, ten of them the divider with two quotient bits each
// rst_n clears the valid bits and the threshold
// each stage holds only while it is full and the stage after it is held, so
// bubbles close up and a stalled output does not stop the input until all are full
module segment_intersect_2d (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [sgi_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // t_first, t_second, hit_x, hit_y
  output logic [sgi_pkg::OUT_DWP-1:0]  out_tdata,
  // status
  output logic [1:0]                   out_tuser,
  input  logic                         cfg_we,
  input  logic [sgi_pkg::THR_W-1:0]    cfg_wdata
);
  import sgi_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic [NST-1:0]   v_r;
  logic [NST-1:0]   en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready = en[PS_DIFF];

  // differences
  logic signed [COORD_W-1:0] c_in [8];
  logic signed [DIFF_W-1:0]  dax_r, day_r, dbx_r, dby_r, rx_r, ry_r;
  logic signed [COORD_W-1:0] asx0_r, asy0_r;

  for (genvar i = 0; i < 8; i++) begin : g_unpack
    assign c_in[i] = in_tdata[i*COORD_W +: COORD_W];
  end

  function automatic logic signed [DIFF_W-1:0] sub_c(logic signed [COORD_W-1:0] a,
                                                     logic signed [COORD_W-1:0] b);
    sub_c = DIFF_W'(a) - DIFF_W'(b);
  endfunction

  always_ff @(posedge clk) begin
    if (en[PS_DIFF]) begin
      dax_r  <= sub_c(c_in[2], c_in[0]);
      day_r  <= sub_c(c_in[3], c_in[1]);
      dbx_r  <= sub_c(c_in[6], c_in[4]);
      dby_r  <= sub_c(c_in[7], c_in[5]);
      rx_r   <= sub_c(c_in[4], c_in[0]);
      ry_r   <= sub_c(c_in[5], c_in[1]);
      asx0_r <= c_in[0];
      asy0_r <= c_in[1];
    end
  end

  // products
  logic signed [PROD_W-1:0]  pd1_r, pd2_r, pa1_r, pb1_r, pa2_r, pb2_r;
  logic signed [COORD_W-1:0] asx1_r, asy1_r;
  logic signed [DIFF_W-1:0]  dax1_r, day1_r;

  always_ff @(posedge clk) begin
    if (en[PS_PROD]) begin
      pd1_r  <= dax_r * dby_r;
      pd2_r  <= day_r * dbx_r;
      pa1_r  <= rx_r * dby_r;
      pb1_r  <= ry_r * dbx_r;
      pa2_r  <= rx_r * day_r;
      pb2_r  <= ry_r * dax_r;
      asx1_r <= asx0_r;
      asy1_r <= asy0_r;
      dax1_r <= dax_r;
      day1_r <= day_r;
    end
  end

  // determinant and numerators
  logic signed [SUM_W-1:0]   det_r, n1_r, n2_r;
  logic signed [COORD_W-1:0] asx2_r, asy2_r;
  logic signed [DIFF_W-1:0]  dax2_r, day2_r;

  always_ff @(posedge clk) begin
    if (en[PS_SUB]) begin
      det_r  <= SUM_W'(pd1_r) - SUM_W'(pd2_r);
      n1_r   <= SUM_W'(pa1_r) - SUM_W'(pb1_r);
      n2_r   <= SUM_W'(pa2_r) - SUM_W'(pb2_r);
      asx2_r <= asx1_r;
      asy2_r <= asy1_r;
      dax2_r <= dax1_r;
      day2_r <= day1_r;
    end
  end

  // magnitudes, signs, parallel test
  logic [SUM_W-1:0] dmag_nxt, dmag_r, n1m_r, n2m_r;
  side_t            side_abs_r;

  assign dmag_nxt = det_r[SUM_W-1] ? SUM_W'(-det_r) : SUM_W'(det_r);

  always_ff @(posedge clk) begin
    if (en[PS_ABS]) begin
      dmag_r          <= dmag_nxt;
      n1m_r           <= n1_r[SUM_W-1] ? SUM_W'(-n1_r) : SUM_W'(n1_r);
      n2m_r           <= n2_r[SUM_W-1] ? SUM_W'(-n2_r) : SUM_W'(n2_r);
      side_abs_r.par  <= (dmag_nxt <= SUM_W'(thr_r));
      side_abs_r.neg1 <= n1_r[SUM_W-1] ^ det_r[SUM_W-1];
      side_abs_r.neg2 <= n2_r[SUM_W-1] ^ det_r[SUM_W-1];
      side_abs_r.asx  <= asx2_r;
      side_abs_r.asy  <= asy2_r;
      side_abs_r.dax  <= dax2_r;
      side_abs_r.day  <= day2_r;
    end
  end

  // two dividers side by side
  logic [T_W-1:0] q1, q2;
  logic           ovf1, ovf2;
  side_t          side_r [DIV_ST];

  sgi_div u_div1 (
    .clk      (clk),
    .stage_en (en[PS_DIV0 +: DIV_ST]),
    .num_mag  (n1m_r),
    .den_mag  (dmag_r),
    .quot     (q1),
    .ovf      (ovf1)
  );

  sgi_div u_div2 (
    .clk      (clk),
    .stage_en (en[PS_DIV0 +: DIV_ST]),
    .num_mag  (n2m_r),
    .den_mag  (dmag_r),
    .quot     (q2),
    .ovf      (ovf2)
  );

  for (genvar s = 0; s < DIV_ST; s++) begin : g_side
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[PS_DIV0]) begin
          side_r[0] <= side_abs_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[PS_DIV0 + s]) begin
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  // sign, saturation and classification
  localparam logic [T_W-1:0] LIM = T_W'(1) << (T_W - 1);
  localparam logic [T_W-1:0] ONE = T_W'(1) << T_FRAC;

  function automatic logic [T_W-1:0] sat_t(logic [T_W-1:0] q, logic o, logic neg);
    logic [T_W-1:0] m;
    if (neg) begin
      m     = (o || q > LIM) ? LIM : q;
      sat_t = T_W'(-m);
    end else begin
      m     = (o || q > LIM - T_W'(1)) ? LIM - T_W'(1) : q;
      sat_t = m;
    end
  endfunction

  side_t          side_d;
  logic [T_W-1:0] t1_v, t2_v;
  logic           in1, in2;
  logic [T_W-1:0] t1_r, t2_r;
  status_t        st_r;
  side_t          side_sat_r;

  assign side_d = side_r[DIV_ST-1];
  assign t1_v   = sat_t(q1, ovf1, side_d.neg1);
  assign t2_v   = sat_t(q2, ovf2, side_d.neg2);
  assign in1    = !t1_v[T_W-1] && (t1_v <= ONE);
  assign in2    = !t2_v[T_W-1] && (t2_v <= ONE);

  always_ff @(posedge clk) begin
    if (en[PS_SAT]) begin
      side_sat_r <= side_d;
      if (side_d.par) begin
        t1_r <= '0;
        t2_r <= '0;
        st_r <= ST_NONE;
      end else begin
        t1_r <= t1_v;
        t2_r <= t2_v;
        st_r <= (in1 && in2) ? ST_INSIDE : ST_OUTSIDE;
      end
    end
  end

  // point products
  logic signed [HIT_PW-1:0]  px_r, py_r;
  logic [T_W-1:0]            t1m_r, t2m_r;
  status_t                   stm_r;
  logic signed [COORD_W-1:0] asxm_r, asym_r;

  always_ff @(posedge clk) begin
    if (en[PS_MUL]) begin
      px_r   <= HIT_PW'(side_sat_r.dax) * HIT_PW'($signed(t1_r));
      py_r   <= HIT_PW'(side_sat_r.day) * HIT_PW'($signed(t1_r));
      t1m_r  <= t1_r;
      t2m_r  <= t2_r;
      stm_r  <= st_r;
      asxm_r <= side_sat_r.asx;
      asym_r <= side_sat_r.asy;
    end
  end

  // floor to coordinate grid and add the start point
  logic [T_W-1:0]     t1o_r, t2o_r;
  logic [COORD_W-1:0] hx_r, hy_r;
  status_t            sto_r;

  always_ff @(posedge clk) begin
    if (en[PS_OUT]) begin
      t1o_r <= t1m_r;
      t2o_r <= t2m_r;
      sto_r <= stm_r;
      if (stm_r == ST_INSIDE) begin
        hx_r <= asxm_r + px_r[T_FRAC +: COORD_W];
        hy_r <= asym_r + py_r[T_FRAC +: COORD_W];
      end else begin
        hx_r <= '0;
        hy_r <= '0;
      end
    end
  end

  assign out_tvalid = v_r[PS_OUT];
  assign out_tuser  = sto_r;
  assign out_tdata  = OUT_DWP'({hy_r, hx_r, t2o_r, t1o_r});

  `include "segment_intersect_2d_defines.svh"

  `SGI_ASSERT_NOW(a_full_when_blocked, !in_tready, &v_r, "input blocked with a bubble in the pipe")
  `SGI_ASSERT_NOW(a_none_is_zero, out_tvalid && out_tuser == ST_NONE, out_tdata == '0, "parallel result carries data")
  `SGI_ASSERT_NOW(a_inside_range, out_tvalid && out_tuser == ST_INSIDE, !out_tdata[T_W-1] && out_tdata[T_W-1:0] <= ONE, "inside hit with t_first outside unit range")
  `SGI_ASSERT_NEXT(a_hold_on_stall, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

// ----- bench/tb_segment_intersect_2d.sv -----
// self-checking bench for segment_intersect_2d: random and directed segment pairs
module tb_segment_intersect_2d;
  import sgi_pkg::*;

  typedef struct {
    status_t                 status;
    logic signed [T_W-1:0]     t_first;
    logic signed [T_W-1:0]     t_second;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
  } crossing_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DWP-1:0]  out_tdata;
  logic [1:0]          out_tuser;
  logic                cfg_we = 1'b0;
  logic [THR_W-1:0]    cfg_wdata = '0;

  logic [IN_W-1:0]  pending_pairs[$];
  crossing_t        expected_hits[$];
  logic [THR_W-1:0] threshold = '0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               mismatches = 0;
  int               words_in = 0;
  int               words_out = 0;
  int               inside_seen = 0;
  int               outside_seen = 0;
  int               parallel_seen = 0;
  int               quiet_cycles = 0;
  localparam int    QUIET_LIMIT = 5000;

  segment_intersect_2d uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint div_saturate(longint num, longint unsigned dmag, bit det_neg);
    longint unsigned m;
    longint unsigned q;
    longint unsigned lim;
    m = (num < 0) ? longint'(-num) : longint'(num);
    q = (m << T_FRAC) / dmag;
    lim = 64'd1 << (T_W - 1);
    if ((num < 0) != det_neg) begin
      if (q > lim) q = lim;
      return -longint'(q);
    end
    if (q > lim - 1) q = lim - 1;
    return longint'(q);
  endfunction

  function automatic crossing_t predict_crossing(logic [IN_W-1:0] w, logic [THR_W-1:0] thr);
    longint c[8];
    longint dax, day, dbx, dby, rx, ry, det, t1, t2, hx, hy;
    longint unsigned dmag;
    crossing_t r;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(w[COORD_W*i +: COORD_W]));
    dax = c[2] - c[0];
    day = c[3] - c[1];
    dbx = c[6] - c[4];
    dby = c[7] - c[5];
    rx  = c[4] - c[0];
    ry  = c[5] - c[1];
    det = dax * dby - day * dbx;
    dmag = (det < 0) ? longint'(-det) : longint'(det);
    t1 = 0; t2 = 0; hx = 0; hy = 0;
    r.status = ST_NONE;
    if (dmag > {32'd0, thr}) begin
      t1 = div_saturate(rx * dby - ry * dbx, dmag, det < 0);
      t2 = div_saturate(rx * day - ry * dax, dmag, det < 0);
      if (t1 >= 0 && t1 <= (64'sd1 << T_FRAC) && t2 >= 0 && t2 <= (64'sd1 << T_FRAC)) begin
        r.status = ST_INSIDE;
        // arithmetic shift floors toward minus infinity
        hx = c[0] + ((dax * t1) >>> T_FRAC);
        hy = c[1] + ((day * t1) >>> T_FRAC);
      end else begin
        r.status = ST_OUTSIDE;
      end
    end
    r.t_first = t1[T_W-1:0];
    r.t_second = t2[T_W-1:0];
    r.hit_x = hx[COORD_W-1:0];
    r.hit_y = hy[COORD_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver: a word stays on the bus until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_hits.push_back(predict_crossing(in_tdata, threshold));
        words_in++;
      end
      if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tdata <= pending_pairs.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    crossing_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (out_tvalid && out_tready) begin
        words_out++;
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected word", out_tuser, -1);
        end else begin
          e = expected_hits.pop_front();
          if (out_tuser != e.status) report_mismatch("status", out_tuser, e.status);
          if ($signed(out_tdata[T_W-1:0]) != e.t_first)
            report_mismatch("t_first", $signed(out_tdata[T_W-1:0]), e.t_first);
          if ($signed(out_tdata[2*T_W-1:T_W]) != e.t_second)
            report_mismatch("t_second", $signed(out_tdata[2*T_W-1:T_W]), e.t_second);
          if ($signed(out_tdata[2*T_W +: COORD_W]) != e.hit_x)
            report_mismatch("hit_x", $signed(out_tdata[2*T_W +: COORD_W]), e.hit_x);
          if ($signed(out_tdata[2*T_W+COORD_W +: COORD_W]) != e.hit_y)
            report_mismatch("hit_y", $signed(out_tdata[2*T_W+COORD_W +: COORD_W]), e.hit_y);
          case (e.status)
            ST_INSIDE:  inside_seen++;
            ST_OUTSIDE: outside_seen++;
            default:    parallel_seen++;
          endcase
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout with %0d words outstanding", expected_hits.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_pair(int asx, int asy, int aex, int aey,
                          int bsx, int bsy, int bex, int bey);
    logic [IN_W-1:0] w;
    w = {bey[15:0], bex[15:0], bsy[15:0], bsx[15:0],
         aey[15:0], aex[15:0], asy[15:0], asx[15:0]};
    pending_pairs.push_back(w);
  endtask

  function automatic int near_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  task automatic add_random_pairs(int n);
    int c[8];
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 99);
      for (int i = 0; i < 8; i++) c[i] = near_coord();
      if (mode < 25) begin
        // raw noise over the whole field
        for (int i = 0; i < 8; i++) c[i] = int'($urandom_range(0, 65535)) - 32768;
      end else if (mode < 45) begin
        // nearly parallel: b direction copies a with a small wobble
        c[6] = c[4] + (c[2] - c[0]) + int'($urandom_range(0, 6)) - 3;
        c[7] = c[5] + (c[3] - c[1]) + int'($urandom_range(0, 6)) - 3;
      end else if (mode < 55) begin
        // b starts on a's start point
        c[4] = c[0];
        c[5] = c[1];
      end
      add_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    end
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || expected_hits.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    threshold = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cases with the zero threshold
    write_threshold('0);
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(0, 0, 16, 16, 0, 16, 16, 0);
    add_pair(0, 0, 16, 0, 32, -16, 32, 16);
    add_pair(0, 0, 16, 0, 16, -16, 16, 16);
    add_pair(0, 0, 16, 0, 0, -16, 0, 16);
    add_pair(0, 0, 16, 0, -16, -16, -16, 16);
    add_pair(0, 0, 1, 0, 30000, -100, 30000, 100);
    add_pair(0, 0, 1, 0, -30000, -100, -30000, 100);
    add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
    add_pair(0, 0, 32767, 1, -1, -32768, 0, 32767);
    add_pair(0, 16, 16, 0, 0, 0, 16, 16);
    add_pair(5, 3, -7, -9, -5, 4, 3, -11);
    add_pair(0, 0, 16, 16, 8, 8, 24, 24);
    add_pair(0, 0, 3, 0, 1, -1, 1, 2);
    add_random_pairs(100);
    wait_drained();

    // sender pauses
    send_idle_pct = 85;
    write_threshold(32'd300);
    add_random_pairs(110);
    wait_drained();

    // receiver stalls
    send_idle_pct = 0;
    stall_pct = 85;
    write_threshold(32'hFFFF_FFFF);
    add_random_pairs(60);
    wait_drained();

    send_idle_pct = 37;
    stall_pct = 37;
    write_threshold($urandom_range(0, 20000));
    add_random_pairs(130);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 0;
    write_threshold(32'd1);
    add_random_pairs(130);
    wait_drained();

    $display("sent %0d pairs, checked %0d results over five threshold settings",
             words_in, words_out);
    $display("inside %0d, outside %0d, parallel %0d, mismatches %0d",
             inside_seen, outside_seen, parallel_seen, mismatches);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
